// ===== rtl/rbpq_pkg.sv =====
package rbpq_pkg;

  localparam int unsigned NUM_PROCS = 32;
  localparam int unsigned NUM_HARTS = 2;
  localparam int unsigned NUM_LISTS = 2;

  localparam int unsigned PROC_W = 5;
  localparam int unsigned LINK_W = PROC_W + 1;
  localparam int unsigned HART_W = 1;

  typedef logic [PROC_W-1:0] proc_t;
  typedef logic [LINK_W-1:0] link_t;
  typedef logic [HART_W-1:0] hart_t;

  localparam link_t NIL_LINK = LINK_W'(NUM_PROCS);

  localparam logic LIST_READY   = 1'b0;
  localparam logic LIST_BLOCKED = 1'b1;

  typedef enum logic [1:0] {
    OP_INS_READY   = 2'd0,
    OP_INS_BLOCKED = 2'd1,
    OP_SCHEDULE    = 2'd2,
    OP_WAKE        = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE        = 2'd0,
    ST_QUEUED      = 2'd1,
    ST_NOT_BLOCKED = 2'd2,
    ST_EMPTY       = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MEM_NONE    = 2'd0,
    MEM_READY   = 2'd1,
    MEM_BLOCKED = 2'd2
  } mem_e;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

// ===== rtl/ready_blocked_process_queues.sv =====
// per-hart fifo ready queues and blocked lists of process ids
// input channel: in_valid_i / in_ready_o with opcode_i, hart_i, target_proc_i
//   insert ready, insert blocked, schedule next, wake parent
// output channel: out_valid_o / out_ready_i with status_o, run_proc_o,
//   run_valid_o; exactly one result word per input word, in order
// a taken input word goes to the capture register; the list update then
//   writes its result to the output register when that register is free
// the controller does the capture and then the list update, so no new
//   word is taken until the list update of the last one is done
// the next input word is taken while a result still waits in the
//   output register; its update holds until that result is taken
// a stalled receiver holds the result and then stops the input side
// reset: all queues empty, no process in any list, output channel idle
module ready_blocked_process_queues import rbpq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [0:0] hart_i,
  input  logic [4:0] target_proc_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [4:0] run_proc_o,
  output logic       run_valid_o
);

  cmd_t cmd;

  rbpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  rbpq_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .opcode_i      (opcode_i),
    .hart_i        (hart_i),
    .target_proc_i (target_proc_i),
    .status_o      (status_o),
    .run_proc_o    (run_proc_o),
    .run_valid_o   (run_valid_o)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input word taken while another is in flight");

  a_run_means_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_valid_o |-> status_o == ST_DONE)
    else $error("scheduled process with non-done status");

  a_run_proc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_valid_o |-> run_proc_o == '0)
    else $error("run_proc nonzero without a scheduled process");

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.capture && cmd.execute))
    else $error("capture and update in the same cycle");

endmodule

// ===== rtl/rbpq_ctrl.sv =====
module rbpq_ctrl import rbpq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   in_fire;
  logic   exec_go;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign exec_go     = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  assign cmd_o.capture = in_fire;
  assign cmd_o.execute = exec_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/rbpq_datapath.sv =====
module rbpq_datapath import rbpq_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cmd_t           cmd_i,
  input  logic [1:0]     opcode_i,
  input  logic [0:0]     hart_i,
  input  logic [4:0]     target_proc_i,
  output logic [1:0]     status_o,
  output logic [4:0]     run_proc_o,
  output logic           run_valid_o
);

  opcode_e op_q;
  hart_t   hart_q;
  proc_t   tp_q;

  link_t head_q [NUM_LISTS][NUM_HARTS];
  link_t tail_q [NUM_LISTS][NUM_HARTS];
  link_t head_d [NUM_LISTS][NUM_HARTS];
  link_t tail_d [NUM_LISTS][NUM_HARTS];
  link_t next_q [NUM_PROCS];
  link_t prev_q [NUM_PROCS];
  link_t next_d [NUM_PROCS];
  link_t prev_d [NUM_PROCS];
  mem_e  mem_q [NUM_PROCS];
  hart_t owner_q [NUM_PROCS];

  status_e status_q, status_d;
  proc_t   run_q, run_d;
  logic    run_valid_q, run_valid_d;

  logic  in_range;
  proc_t sel_p;
  link_t sel_n;
  link_t sel_b;
  link_t app_t;
  logic  unl_en;
  logic  unl_list;
  logic  app_en;
  logic  app_list;
  logic  mem_wr;
  mem_e  mem_new;
  logic  owner_wr;

  assign in_range = ({1'b0, tp_q} < NIL_LINK);
  assign sel_p    = (op_q == OP_SCHEDULE) ? head_q[LIST_READY][hart_q][PROC_W-1:0] : tp_q;
  assign sel_n    = next_q[sel_p];
  assign sel_b    = prev_q[sel_p];

  // operation decode
  always_comb begin
    status_d    = ST_DONE;
    run_d       = '0;
    run_valid_d = 1'b0;
    unl_en      = 1'b0;
    unl_list    = LIST_READY;
    app_en      = 1'b0;
    app_list    = LIST_READY;
    mem_wr      = 1'b0;
    mem_new     = MEM_NONE;
    owner_wr    = 1'b0;
    unique case (op_q)
      OP_INS_READY, OP_INS_BLOCKED: begin
        if (!in_range || mem_q[tp_q] != MEM_NONE) begin
          status_d = ST_QUEUED;
        end else begin
          app_en   = 1'b1;
          app_list = (op_q == OP_INS_READY) ? LIST_READY : LIST_BLOCKED;
          mem_wr   = 1'b1;
          mem_new  = (op_q == OP_INS_READY) ? MEM_READY : MEM_BLOCKED;
          owner_wr = 1'b1;
        end
      end
      OP_SCHEDULE: begin
        if (head_q[LIST_READY][hart_q] >= NIL_LINK) begin
          status_d = ST_EMPTY;
        end else begin
          unl_en      = 1'b1;
          unl_list    = LIST_READY;
          mem_wr      = 1'b1;
          mem_new     = MEM_NONE;
          run_d       = sel_p;
          run_valid_d = 1'b1;
        end
      end
      OP_WAKE: begin
        if (!in_range || mem_q[tp_q] != MEM_BLOCKED || owner_q[tp_q] != hart_q) begin
          status_d = ST_NOT_BLOCKED;
        end else begin
          unl_en   = 1'b1;
          unl_list = LIST_BLOCKED;
          app_en   = 1'b1;
          app_list = LIST_READY;
          mem_wr   = 1'b1;
          mem_new  = MEM_READY;
        end
      end
      default: begin
        status_d = ST_DONE;
      end
    endcase
  end

  // list update: unlink first, then append
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    next_d = next_q;
    prev_d = prev_q;
    app_t  = NIL_LINK;
    if (unl_en) begin
      if (sel_b < NIL_LINK) begin
        next_d[sel_b[PROC_W-1:0]] = sel_n;
      end else begin
        head_d[unl_list][hart_q] = sel_n;
      end
      if (sel_n < NIL_LINK) begin
        prev_d[sel_n[PROC_W-1:0]] = sel_b;
      end else begin
        tail_d[unl_list][hart_q] = sel_b;
      end
      next_d[sel_p] = NIL_LINK;
      prev_d[sel_p] = NIL_LINK;
    end
    if (app_en) begin
      app_t = tail_d[app_list][hart_q];
      next_d[sel_p] = NIL_LINK;
      prev_d[sel_p] = app_t;
      if (app_t < NIL_LINK) begin
        next_d[app_t[PROC_W-1:0]] = {1'b0, sel_p};
      end else begin
        head_d[app_list][hart_q] = {1'b0, sel_p};
      end
      tail_d[app_list][hart_q] = {1'b0, sel_p};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= opcode_e'(opcode_i);
      hart_q <= hart_i;
      tp_q   <= target_proc_i;
    end
    if (cmd_i.execute) begin
      next_q      <= next_d;
      prev_q      <= prev_d;
      status_q    <= status_d;
      run_q       <= run_d;
      run_valid_q <= run_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < NUM_LISTS; l++) begin
        for (int h = 0; h < NUM_HARTS; h++) begin
          head_q[l][h] <= NIL_LINK;
          tail_q[l][h] <= NIL_LINK;
        end
      end
      for (int i = 0; i < NUM_PROCS; i++) begin
        mem_q[i]   <= MEM_NONE;
        owner_q[i] <= '0;
      end
    end else if (cmd_i.execute) begin
      head_q <= head_d;
      tail_q <= tail_d;
      if (mem_wr) begin
        mem_q[sel_p] <= mem_new;
      end
      if (owner_wr) begin
        owner_q[sel_p] <= hart_q;
      end
    end
  end

  assign status_o    = status_q;
  assign run_proc_o  = run_q;
  assign run_valid_o = run_valid_q;

endmodule

// ===== tb/sv/tb_ready_blocked_process_queues.sv =====
`timescale 1ns / 1ps

module tb_ready_blocked_process_queues;
  import rbpq_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1500;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct packed {
    opcode_e op;
    hart_t   hart;
    proc_t   pid;
  } sched_word_t;

  typedef struct packed {
    status_e status;
    proc_t   run_proc;
    logic    run_valid;
  } sched_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] opcode_i = '0;
  logic [0:0] hart_i = '0;
  logic [4:0] target_proc_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] status_o;
  logic [4:0] run_proc_o;
  logic       run_valid_o;

  sched_word_t   word_q[$];
  sched_result_t outcome_q[$];
  proc_t         parked[NUM_HARTS][$];
  int            word_total = 0;
  int            words_taken = 0;
  int            mismatch_count = 0;
  int            stall_cycles = 0;
  int            send_idle_pct;
  int            recv_idle_pct;

  // shadow of the hart lists
  link_t list_head[NUM_HARTS][NUM_LISTS];
  link_t list_tail[NUM_HARTS][NUM_LISTS];
  link_t next_of[NUM_PROCS];
  link_t prev_of[NUM_PROCS];
  mem_e  member_of[NUM_PROCS];
  hart_t owner_of[NUM_PROCS];

  ready_blocked_process_queues u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .hart_i        (hart_i),
    .target_proc_i (target_proc_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .run_proc_o    (run_proc_o),
    .run_valid_o   (run_valid_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always_comb begin
    if (words_taken < word_total / 3) begin
      send_idle_pct = 10;
      recv_idle_pct = 49;
    end else if (words_taken < (2 * word_total) / 3) begin
      send_idle_pct = 49;
      recv_idle_pct = 10;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  function automatic void add_word(opcode_e op, hart_t h, proc_t p);
    sched_word_t w;
    w.op   = op;
    w.hart = h;
    w.pid  = p;
    word_q.push_back(w);
  endfunction

  function automatic void link_append(hart_t h, logic lst, proc_t p);
    link_t t;
    t = list_tail[h][lst];
    next_of[p] = NIL_LINK;
    prev_of[p] = t;
    if (t < NIL_LINK) next_of[t[PROC_W-1:0]] = link_t'(p);
    else list_head[h][lst] = link_t'(p);
    list_tail[h][lst] = link_t'(p);
  endfunction

  function automatic void link_remove(hart_t h, logic lst, proc_t p);
    link_t n;
    link_t b;
    n = next_of[p];
    b = prev_of[p];
    if (b < NIL_LINK) next_of[b[PROC_W-1:0]] = n;
    else list_head[h][lst] = n;
    if (n < NIL_LINK) prev_of[n[PROC_W-1:0]] = b;
    else list_tail[h][lst] = b;
    next_of[p] = NIL_LINK;
    prev_of[p] = NIL_LINK;
  endfunction

  function automatic sched_result_t apply_word(sched_word_t w);
    sched_result_t r;
    link_t hd;
    r.status    = ST_DONE;
    r.run_proc  = '0;
    r.run_valid = 1'b0;
    case (w.op)
      OP_INS_READY, OP_INS_BLOCKED: begin
        if (member_of[w.pid] != MEM_NONE) begin
          r.status = ST_QUEUED;
        end else if (w.op == OP_INS_READY) begin
          link_append(w.hart, LIST_READY, w.pid);
          member_of[w.pid] = MEM_READY;
          owner_of[w.pid]  = w.hart;
        end else begin
          link_append(w.hart, LIST_BLOCKED, w.pid);
          member_of[w.pid] = MEM_BLOCKED;
          owner_of[w.pid]  = w.hart;
        end
      end
      OP_SCHEDULE: begin
        hd = list_head[w.hart][LIST_READY];
        if (hd >= NIL_LINK) begin
          r.status = ST_EMPTY;
        end else begin
          link_remove(w.hart, LIST_READY, hd[PROC_W-1:0]);
          member_of[hd[PROC_W-1:0]] = MEM_NONE;
          r.run_proc  = hd[PROC_W-1:0];
          r.run_valid = 1'b1;
        end
      end
      default: begin
        if (member_of[w.pid] != MEM_BLOCKED || owner_of[w.pid] != w.hart) begin
          r.status = ST_NOT_BLOCKED;
        end else begin
          link_remove(w.hart, LIST_BLOCKED, w.pid);
          link_append(w.hart, LIST_READY, w.pid);
          member_of[w.pid] = MEM_READY;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : drive_words
    sched_word_t w;
    logic        free;
    int          i;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      opcode_i      <= OP_INS_READY;
      hart_i        <= '0;
      target_proc_i <= '0;
      words_taken   <= 0;
      for (i = 0; i < NUM_HARTS; i++) begin
        list_head[i][LIST_READY]   = NIL_LINK;
        list_tail[i][LIST_READY]   = NIL_LINK;
        list_head[i][LIST_BLOCKED] = NIL_LINK;
        list_tail[i][LIST_BLOCKED] = NIL_LINK;
      end
      for (i = 0; i < NUM_PROCS; i++) begin
        next_of[i]   = NIL_LINK;
        prev_of[i]   = NIL_LINK;
        member_of[i] = MEM_NONE;
        owner_of[i]  = '0;
      end
    end else begin
      free = !in_valid_i || in_ready_o;
      if (in_valid_i && in_ready_o) begin
        w.op   = opcode_e'(opcode_i);
        w.hart = hart_i;
        w.pid  = target_proc_i;
        outcome_q.push_back(apply_word(w));
        words_taken <= words_taken + 1;
      end
      if (free) begin
        if (word_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          w = word_q.pop_front();
          in_valid_i    <= 1'b1;
          opcode_i      <= w.op;
          hart_i        <= w.hart;
          target_proc_i <= w.pid;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_results
    sched_result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (outcome_q.size() == 0) begin
          $error("result word with no pending expectation");
          mismatch_count++;
        end else begin
          want = outcome_q.pop_front();
          if (status_o !== want.status) begin
            $error("field status expected %0d actual %0d", want.status, status_o);
            mismatch_count++;
          end
          if (run_proc_o !== want.run_proc) begin
            $error("field run_proc expected %0d actual %0d", want.run_proc, run_proc_o);
            mismatch_count++;
          end
          if (run_valid_o !== want.run_valid) begin
            $error("field run_valid expected %0d actual %0d", want.run_valid, run_valid_o);
            mismatch_count++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : run_test
    int    k;
    int    r;
    int    g;
    int    j;
    int    idx;
    logic  seen;
    hart_t h;
    proc_t p;

    // empty queues, wrong hart, middle and edge unlinks
    add_word(OP_SCHEDULE,    1'b0, 5'd0);
    add_word(OP_SCHEDULE,    1'b1, 5'd31);
    add_word(OP_WAKE,        1'b0, 5'd3);
    add_word(OP_INS_READY,   1'b0, 5'd0);
    add_word(OP_INS_READY,   1'b0, 5'd31);
    add_word(OP_INS_READY,   1'b1, 5'd0);
    add_word(OP_INS_BLOCKED, 1'b0, 5'd31);
    add_word(OP_INS_BLOCKED, 1'b1, 5'd10);
    add_word(OP_INS_BLOCKED, 1'b1, 5'd11);
    add_word(OP_INS_BLOCKED, 1'b1, 5'd12);
    add_word(OP_WAKE,        1'b0, 5'd11);
    add_word(OP_WAKE,        1'b1, 5'd0);
    add_word(OP_WAKE,        1'b1, 5'd11);
    add_word(OP_WAKE,        1'b1, 5'd12);
    add_word(OP_WAKE,        1'b1, 5'd10);
    add_word(OP_INS_BLOCKED, 1'b0, 5'd21);
    add_word(OP_SCHEDULE,    1'b1, 5'd21);
    add_word(OP_SCHEDULE,    1'b1, 5'd10);
    add_word(OP_SCHEDULE,    1'b1, 5'd0);
    add_word(OP_SCHEDULE,    1'b1, 5'd0);
    add_word(OP_SCHEDULE,    1'b0, 5'd0);
    add_word(OP_SCHEDULE,    1'b0, 5'd0);
    add_word(OP_SCHEDULE,    1'b0, 5'd0);
    add_word(OP_WAKE,        1'b0, 5'd21);
    add_word(OP_SCHEDULE,    1'b0, 5'd31);

    // mostly sensible traffic, wakes aimed at parked processes
    for (k = 0; k < RANDOM_WORDS; k++) begin
      h = hart_t'($urandom_range(NUM_HARTS - 1));
      p = proc_t'($urandom_range(NUM_PROCS - 1));
      r = $urandom_range(99);
      if (r < 10) begin
        add_word(opcode_e'($urandom_range(3)), h, p);
      end else if (r < 36) begin
        add_word(OP_INS_READY, h, p);
      end else if (r < 56) begin
        seen = 1'b0;
        for (g = 0; g < NUM_HARTS; g++) begin
          for (j = 0; j < parked[g].size(); j++) begin
            if (parked[g][j] == p) seen = 1'b1;
          end
        end
        if (!seen) parked[h].push_back(p);
        add_word(OP_INS_BLOCKED, h, p);
      end else if (r < 80) begin
        add_word(OP_SCHEDULE, h, p);
      end else begin
        if (parked[h].size() > 0 && $urandom_range(3) != 0) begin
          idx = $urandom_range(parked[h].size() - 1);
          p = parked[h][idx];
          parked[h].delete(idx);
        end
        add_word(OP_WAKE, h, p);
      end
    end
    word_total = word_q.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (word_q.size() > 0 || in_valid_i || outcome_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && outcome_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
